/* hdl/cwlr_pkg.sv */
// ----------------------------------------------------------------------------
// Weight layout reorder package
// Register codes, configuration record and the small helpers that front and
// back both use to clamp dimension and element-size registers.
// ----------------------------------------------------------------------------
package cwlr_pkg;

   localparam int unsigned CSR_DATA_BITS  = 13;
   localparam int unsigned CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUT_CHANNELS  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IN_CHANNELS   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_HEIGHT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KERNEL_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAYOUT_MODE   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLIP_SIGN     = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ELEMENT_BYTES = 3'd6;

   localparam logic       LAYOUT_OHWI = 1'b0;
   localparam logic [7:0] SIGN_FLIP   = 8'h80;

   localparam int unsigned DEST_ADDR_BITS = 24;
   localparam int unsigned RSP_BITS       = DEST_ADDR_BITS + 10;
   localparam int unsigned MID_DEPTH      = 4;
   localparam int unsigned OUT_DEPTH      = 8;
   localparam int unsigned NUM_STAGES     = 4;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] out_channels;
      logic [CSR_DATA_BITS-1:0] in_channels;
      logic [CSR_DATA_BITS-1:0] kernel_height;
      logic [CSR_DATA_BITS-1:0] kernel_width;
      logic                     layout_mode;
      logic                     flip_sign;
      logic [2:0]               element_bytes;
   } cfg_type;

   // zero acts as one, anything above 2**dim_bits acts as 2**dim_bits
   function automatic logic [16:0] dim_eff(input logic [CSR_DATA_BITS-1:0] v,
                                           input int unsigned dim_bits);
      logic [17:0] lim;
      logic [17:0] ve;
      lim = 18'(1) << dim_bits;
      ve  = {5'b0, v};
      if (v == '0) begin
         return 17'd1;
      end
      if (ve > lim) begin
         return lim[16:0];
      end
      return ve[16:0];
   endfunction

   function automatic logic [2:0] eb_eff(input logic [2:0] v);
      if (v == 3'd0) begin
         return 3'd1;
      end
      if (v > 3'd4) begin
         return 3'd4;
      end
      return v;
   endfunction

endpackage

/* hdl/conv_weight_layout_reorder_top.sv */
// ----------------------------------------------------------------------------
// Convolution weight layout reorder
// Streams weight bytes in (out, in, height, width, byte) order and returns the
// byte address of each in the target layout, with an optional sign flip.
// ----------------------------------------------------------------------------
// Usage:
//   Request side: drive req_src_byte and raise req_push; the beat is taken on
//   a clock edge where req_full is low. Result side: while rsp_empty is low
//   the oldest result sits on the rsp_ ports; raise rsp_pop to take it.
//   Configuration: write csr_wdata to register csr_index with csr_we while no
//   beat is in flight; unknown indexes are ignored.
//   Throughput is one byte per cycle while req_full is low. A beat goes
//   through the front counters into a four-entry work queue, then through
//   four multiply-add stages into an eight-entry result queue. The address
//   is built by one multiply-add per stage.
//   Reset clears the position counters and both queues, and loads the
//   registers with dimensions of 1, element size 1 and both modes 0.
//   If the receiver stalls, the result queue fills, the back end stops
//   drawing from the work queue, and req_full rises once that fills too.
// ----------------------------------------------------------------------------
module conv_weight_layout_reorder_top
   import cwlr_pkg::*;
#(
   parameter int unsigned ADDR_BITS = 24,
   parameter int unsigned DIM_BITS  = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [7:0]                  req_src_byte,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [DEST_ADDR_BITS-1:0]   rsp_dest_addr,
   output logic [7:0]                  rsp_dest_byte,
   output logic                        rsp_tensor_done,
   output logic                        rsp_addr_overflow
);

   localparam int unsigned EW = 4 * DIM_BITS + 11;

   cfg_type       cfg_ff, cfg_in;
   logic          mid_push, mid_full, mid_pop, mid_empty;
   logic [EW-1:0] mid_wdata, mid_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OUT_CHANNELS:  cfg_in.out_channels  = csr_wdata;
            CSR_IN_CHANNELS:   cfg_in.in_channels   = csr_wdata;
            CSR_KERNEL_HEIGHT: cfg_in.kernel_height = csr_wdata;
            CSR_KERNEL_WIDTH:  cfg_in.kernel_width  = csr_wdata;
            CSR_LAYOUT_MODE:   cfg_in.layout_mode   = csr_wdata[0];
            CSR_FLIP_SIGN:     cfg_in.flip_sign     = csr_wdata[0];
            CSR_ELEMENT_BYTES: cfg_in.element_bytes = csr_wdata[2:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_channels  <= CSR_DATA_BITS'(1);
         cfg_ff.in_channels   <= CSR_DATA_BITS'(1);
         cfg_ff.kernel_height <= CSR_DATA_BITS'(1);
         cfg_ff.kernel_width  <= CSR_DATA_BITS'(1);
         cfg_ff.layout_mode   <= LAYOUT_OHWI;
         cfg_ff.flip_sign     <= 1'b0;
         cfg_ff.element_bytes <= 3'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = mid_full;

   cwlr_front #(
      .DIM_BITS (DIM_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_push     (req_push),
      .req_src_byte (req_src_byte),
      .q_full       (mid_full),
      .q_push       (mid_push),
      .q_data       (mid_wdata)
   );

   cwlr_queue #(
      .WIDTH (EW),
      .DEPTH (MID_DEPTH)
   ) u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_wdata),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_rdata),
      .empty     (mid_empty)
   );

   cwlr_back #(
      .ADDR_BITS (ADDR_BITS),
      .DIM_BITS  (DIM_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_empty           (mid_empty),
      .q_data            (mid_rdata),
      .q_pop             (mid_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_dest_addr     (rsp_dest_addr),
      .rsp_dest_byte     (rsp_dest_byte),
      .rsp_tensor_done   (rsp_tensor_done),
      .rsp_addr_overflow (rsp_addr_overflow)
   );

endmodule

/* hdl/cwlr_queue.sv */
// ----------------------------------------------------------------------------
// Weight layout reorder queue
// Small register FIFO with a combinational head; push only when not full,
// pop only when not empty.
// ----------------------------------------------------------------------------
module cwlr_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/cwlr_front.sv */
// ----------------------------------------------------------------------------
// Weight layout reorder front end
// Tracks the source position (out, in, row, col, byte), tags each incoming
// beat with its indices in target order and hands it to the work queue.
// ----------------------------------------------------------------------------
module cwlr_front
   import cwlr_pkg::*;
#(
   parameter int unsigned DIM_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      req_push,
   input  logic [7:0]                req_src_byte,
   input  logic                      q_full,
   output logic                      q_push,
   output logic [4*DIM_BITS+10:0]    q_data
);

   localparam int unsigned DW = DIM_BITS + 1;

   logic [DIM_BITS-1:0] out_idx_ff, out_idx_in;
   logic [DIM_BITS-1:0] in_idx_ff,  in_idx_in;
   logic [DIM_BITS-1:0] row_idx_ff, row_idx_in;
   logic [DIM_BITS-1:0] col_idx_ff, col_idx_in;
   logic [1:0]          byte_idx_ff, byte_idx_in;

   logic [DW-1:0]       oc, ic, kh, kw;
   logic [2:0]          eb;
   logic                wrap_byte, wrap_col, wrap_row, wrap_in, wrap_out;
   logic                accept;
   logic [DIM_BITS-1:0] outer, inner;
   logic [7:0]          flipped;

   assign oc = DW'(dim_eff(cfg.out_channels,  DIM_BITS));
   assign ic = DW'(dim_eff(cfg.in_channels,   DIM_BITS));
   assign kh = DW'(dim_eff(cfg.kernel_height, DIM_BITS));
   assign kw = DW'(dim_eff(cfg.kernel_width,  DIM_BITS));
   assign eb = eb_eff(cfg.element_bytes);

   assign accept = req_push & ~q_full;

   // a counter at or past its last value wraps on the next advance
   assign wrap_byte = ({1'b0, byte_idx_ff} + 3'd1) >= eb;
   assign wrap_col  = wrap_byte & (({1'b0, col_idx_ff} + DW'(1)) >= kw);
   assign wrap_row  = wrap_col  & (({1'b0, row_idx_ff} + DW'(1)) >= kh);
   assign wrap_in   = wrap_row  & (({1'b0, in_idx_ff}  + DW'(1)) >= ic);
   assign wrap_out  = wrap_in   & (({1'b0, out_idx_ff} + DW'(1)) >= oc);

   always_comb begin
      byte_idx_in = byte_idx_ff;
      col_idx_in  = col_idx_ff;
      row_idx_in  = row_idx_ff;
      in_idx_in   = in_idx_ff;
      out_idx_in  = out_idx_ff;
      if (accept) begin
         byte_idx_in = wrap_byte ? '0 : byte_idx_ff + 2'd1;
         if (wrap_byte) begin
            col_idx_in = wrap_col ? '0 : col_idx_ff + DIM_BITS'(1);
         end
         if (wrap_col) begin
            row_idx_in = wrap_row ? '0 : row_idx_ff + DIM_BITS'(1);
         end
         if (wrap_row) begin
            in_idx_in = wrap_in ? '0 : in_idx_ff + DIM_BITS'(1);
         end
         if (wrap_in) begin
            out_idx_in = wrap_out ? '0 : out_idx_ff + DIM_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_idx_ff  <= '0;
         in_idx_ff   <= '0;
         row_idx_ff  <= '0;
         col_idx_ff  <= '0;
         byte_idx_ff <= '0;
      end else begin
         out_idx_ff  <= out_idx_in;
         in_idx_ff   <= in_idx_in;
         row_idx_ff  <= row_idx_in;
         col_idx_ff  <= col_idx_in;
         byte_idx_ff <= byte_idx_in;
      end
   end

   // pick the outer and inner channel for the target layout
   always_comb begin
      if (cfg.layout_mode == LAYOUT_OHWI) begin
         outer = out_idx_ff;
         inner = in_idx_ff;
      end else begin
         outer = in_idx_ff;
         inner = out_idx_ff;
      end
   end

   assign flipped = req_src_byte ^ (cfg.flip_sign ? SIGN_FLIP : 8'h00);
   assign q_push  = accept;
   assign q_data  = {wrap_out, flipped, byte_idx_ff, col_idx_ff, row_idx_ff, inner, outer};

endmodule

/* hdl/cwlr_back.sv */
// ----------------------------------------------------------------------------
// Weight layout reorder back end
// Four multiply-add stages build the target address in Horner form and track
// overflow; finished beats land in the result queue. Issue is credit based,
// so the pipeline never stalls.
// ----------------------------------------------------------------------------
module cwlr_back
   import cwlr_pkg::*;
#(
   parameter int unsigned ADDR_BITS = 24,
   parameter int unsigned DIM_BITS  = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        q_empty,
   input  logic [4*DIM_BITS+10:0]      q_data,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [DEST_ADDR_BITS-1:0]   rsp_dest_addr,
   output logic [7:0]                  rsp_dest_byte,
   output logic                        rsp_tensor_done,
   output logic                        rsp_addr_overflow
);

   localparam int unsigned EW  = 4 * DIM_BITS + 11;
   localparam int unsigned DW  = DIM_BITS + 1;
   localparam int unsigned VW  = (ADDR_BITS > DIM_BITS) ? ADDR_BITS : DIM_BITS;
   localparam int unsigned PW  = VW + DIM_BITS + 2;
   localparam int unsigned CRW = $clog2(OUT_DEPTH + 1);

   localparam int unsigned OFS_OUTER = 0;
   localparam int unsigned OFS_INNER = DIM_BITS;
   localparam int unsigned OFS_ROW   = 2 * DIM_BITS;
   localparam int unsigned OFS_COL   = 3 * DIM_BITS;
   localparam int unsigned OFS_BYTE  = 4 * DIM_BITS;
   localparam int unsigned OFS_DATA  = 4 * DIM_BITS + 2;
   localparam int unsigned OFS_DONE  = 4 * DIM_BITS + 10;

   localparam logic [VW-1:0] ADDR_MASK = VW'((PW'(1) << ADDR_BITS) - PW'(1));

   logic [DW-1:0]       oc, ic, kh, kw, last_dim;
   logic [2:0]          eb;
   logic                issue;
   logic [CRW-1:0]      credit_ff, credit_in;
   logic                rsp_full, rsp_take;

   logic                in_val [NUM_STAGES];
   logic [VW-1:0]       in_v   [NUM_STAGES];
   logic                in_ov  [NUM_STAGES];
   logic [EW-1:0]       in_e   [NUM_STAGES];
   logic [DW-1:0]       mul_m  [NUM_STAGES];
   logic [DIM_BITS-1:0] add_a  [NUM_STAGES];
   logic [PW-1:0]       prod   [NUM_STAGES];

   logic                st_val_ff [NUM_STAGES];
   logic [VW-1:0]       st_v_ff   [NUM_STAGES];
   logic                st_ov_ff  [NUM_STAGES];
   logic [EW-1:0]       st_e_ff   [NUM_STAGES];

   logic [VW-1:0]                addr_masked;
   logic [VW+DEST_ADDR_BITS-1:0] addr_ext;
   logic [RSP_BITS-1:0]          rsp_wdata, rsp_rdata;
   logic [DIM_BITS-1:0]          outer_idx;

   assign oc       = DW'(dim_eff(cfg.out_channels,  DIM_BITS));
   assign ic       = DW'(dim_eff(cfg.in_channels,   DIM_BITS));
   assign kh       = DW'(dim_eff(cfg.kernel_height, DIM_BITS));
   assign kw       = DW'(dim_eff(cfg.kernel_width,  DIM_BITS));
   assign eb       = eb_eff(cfg.element_bytes);
   assign last_dim = (cfg.layout_mode == LAYOUT_OHWI) ? ic : oc;

   // one credit per slot of the result queue
   assign rsp_take  = rsp_pop & ~rsp_empty;
   assign issue     = ~q_empty & (credit_ff < CRW'(OUT_DEPTH));
   assign q_pop     = issue;

   always_comb begin
      credit_in = credit_ff;
      if (issue && !rsp_take) begin
         credit_in = credit_ff + CRW'(1);
      end else if (rsp_take && !issue) begin
         credit_in = credit_ff - CRW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   assign outer_idx = q_data[OFS_OUTER +: DIM_BITS];
   assign in_val[0] = issue;
   assign in_v[0]   = VW'(outer_idx);
   assign in_ov[0]  = (PW'(outer_idx) >> ADDR_BITS) != '0;
   assign in_e[0]   = q_data;

   // Horner steps: *kh +row, *kw +col, *last_dim +inner, *eb +byte
   assign mul_m[0] = kh;
   assign mul_m[1] = kw;
   assign mul_m[2] = last_dim;
   assign mul_m[3] = DW'(eb);
   assign add_a[0] = in_e[0][OFS_ROW +: DIM_BITS];
   assign add_a[1] = in_e[1][OFS_COL +: DIM_BITS];
   assign add_a[2] = in_e[2][OFS_INNER +: DIM_BITS];
   assign add_a[3] = DIM_BITS'(in_e[3][OFS_BYTE +: 2]);

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      if (i > 0) begin : g_link
         assign in_val[i] = st_val_ff[i-1];
         assign in_v[i]   = st_v_ff[i-1];
         assign in_ov[i]  = st_ov_ff[i-1];
         assign in_e[i]   = st_e_ff[i-1];
      end

      assign prod[i] = PW'(in_v[i]) * PW'(mul_m[i]) + PW'(add_a[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            st_val_ff[i] <= 1'b0;
         end else begin
            st_val_ff[i] <= in_val[i];
         end
      end

      // low bits stay exact modulo 2**VW; overflow is sticky since every factor is >= 1
      always_ff @(posedge clock) begin
         st_v_ff[i]  <= prod[i][VW-1:0];
         st_ov_ff[i] <= in_ov[i] | ((prod[i] >> ADDR_BITS) != '0);
         st_e_ff[i]  <= in_e[i];
      end
   end

   assign addr_masked = st_v_ff[NUM_STAGES-1] & ADDR_MASK;
   assign addr_ext    = {{DEST_ADDR_BITS{1'b0}}, addr_masked};
   assign rsp_wdata   = {st_e_ff[NUM_STAGES-1][OFS_DONE],
                         st_ov_ff[NUM_STAGES-1],
                         st_e_ff[NUM_STAGES-1][OFS_DATA +: 8],
                         addr_ext[DEST_ADDR_BITS-1:0]};

   cwlr_queue #(
      .WIDTH (RSP_BITS),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (st_val_ff[NUM_STAGES-1]),
      .push_data (rsp_wdata),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_rdata),
      .empty     (rsp_empty)
   );

   assign rsp_dest_addr     = rsp_rdata[DEST_ADDR_BITS-1:0];
   assign rsp_dest_byte     = rsp_rdata[DEST_ADDR_BITS +: 8];
   // credits keep the queue from filling past its depth; full is never hit on push
   assign rsp_addr_overflow = rsp_rdata[DEST_ADDR_BITS + 8] & ~(rsp_full & rsp_empty);
   assign rsp_tensor_done   = rsp_rdata[DEST_ADDR_BITS + 9];

endmodule

/* tb/conv_weight_layout_reorder_top_tb.sv */
// ----------------------------------------------------------------------------
// Weight layout reorder testbench
// Streams weight bytes through the reorder block under many register settings
// and checks every result beat (address, byte, tensor end, overflow) against
// an in-bench placement model. It opens with a short table of hand-picked
// cases, then runs random phases with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module conv_weight_layout_reorder_top_tb;
   import cwlr_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 3'd7;  // decodes to nothing
   localparam longint unsigned DIM_CAP    = 64'd4096;
   localparam int              PLAN_LEN   = 35;
   localparam int              RANDOM_LEN = 1950;

   typedef struct packed {
      logic [DEST_ADDR_BITS-1:0] dest_addr;
      logic [7:0]                dest_byte;
      logic                      tensor_done;
      logic                      addr_overflow;
   } placement_type;

   typedef enum logic {ROW_CSR, ROW_BEAT} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  wdata;
      logic [7:0]                src;
      logic                      pinned;
      placement_type             want;
   } plan_row_type;

   typedef enum {PHASE_SMALL, PHASE_SUBSET, PHASE_STRESS, PHASE_WIDE} phase_kind_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_wdata = '0;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic [7:0]                  req_src_byte = '0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic [DEST_ADDR_BITS-1:0]   rsp_dest_addr;
   logic [7:0]                  rsp_dest_byte;
   logic                        rsp_tensor_done;
   logic                        rsp_addr_overflow;

   conv_weight_layout_reorder_top dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_src_byte      (req_src_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_dest_addr     (rsp_dest_addr),
      .rsp_dest_byte     (rsp_dest_byte),
      .rsp_tensor_done   (rsp_tensor_done),
      .rsp_addr_overflow (rsp_addr_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // placement model state
   cfg_type     layout_cfg = '{13'd1, 13'd1, 13'd1, 13'd1, 1'b0, 1'b0, 3'd1};
   logic [11:0] pos_out = '0;
   logic [11:0] pos_in  = '0;
   logic [11:0] pos_row = '0;
   logic [11:0] pos_col = '0;
   logic [1:0]  pos_byte = '0;

   placement_type pending_placements[$];
   plan_row_type  plan [PLAN_LEN];

   int fail_count   = 0;
   int beats_sent   = 0;
   int results_seen = 0;
   int done_seen    = 0;
   int ovf_seen     = 0;
   int settings     = 0;

   function automatic longint unsigned eff_dim(input logic [CSR_DATA_BITS-1:0] v);
      if (v == '0) begin
         return 64'd1;
      end
      if (v > 13'd4096) begin
         return DIM_CAP;
      end
      return {51'd0, v};
   endfunction

   function automatic longint unsigned eff_elem(input logic [2:0] v);
      if (v == 3'd0) begin
         return 64'd1;
      end
      if (v > 3'd4) begin
         return 64'd4;
      end
      return {61'd0, v};
   endfunction

   function automatic bit at_end(input longint unsigned idx, input longint unsigned lim);
      return idx + 1 >= lim;
   endfunction

   // work out where one source byte lands, then advance the position counters
   function automatic placement_type place_byte(input logic [7:0] src);
      longint unsigned oc, ic, kh, kw, eb, outer, inner, span, addr;
      bit carry;
      placement_type p;
      oc = eff_dim(layout_cfg.out_channels);
      ic = eff_dim(layout_cfg.in_channels);
      kh = eff_dim(layout_cfg.kernel_height);
      kw = eff_dim(layout_cfg.kernel_width);
      eb = eff_elem(layout_cfg.element_bytes);
      if (layout_cfg.layout_mode == LAYOUT_OHWI) begin
         outer = pos_out;
         inner = pos_in;
         span  = ic;
      end else begin
         outer = pos_in;
         inner = pos_out;
         span  = oc;
      end
      // counters are 12 bits and dims at most 4096, so this never exceeds 64 bits
      addr = ((((outer * kh + pos_row) * kw + pos_col) * span + inner) * eb) + pos_byte;
      p.dest_addr     = addr[DEST_ADDR_BITS-1:0];
      p.dest_byte     = src ^ (layout_cfg.flip_sign ? SIGN_FLIP : 8'h00);
      p.addr_overflow = (addr >> DEST_ADDR_BITS) != 0;

      carry    = at_end(pos_byte, eb);
      pos_byte = carry ? 2'd0 : pos_byte + 2'd1;
      if (carry) begin
         carry   = at_end(pos_col, kw);
         pos_col = carry ? 12'd0 : pos_col + 12'd1;
      end
      if (carry) begin
         carry   = at_end(pos_row, kh);
         pos_row = carry ? 12'd0 : pos_row + 12'd1;
      end
      if (carry) begin
         carry  = at_end(pos_in, ic);
         pos_in = carry ? 12'd0 : pos_in + 12'd1;
      end
      if (carry) begin
         carry   = at_end(pos_out, oc);
         pos_out = carry ? 12'd0 : pos_out + 12'd1;
      end
      p.tensor_done = carry;
      return p;
   endfunction

   function automatic plan_row_type reg_write(input logic [CSR_INDEX_BITS-1:0] idx,
                                              input logic [CSR_DATA_BITS-1:0] val);
      return '{ROW_CSR, idx, val, 8'h00, 1'b0, '0};
   endfunction

   function automatic plan_row_type free_beat(input logic [7:0] src);
      return '{ROW_BEAT, CSR_SPARE, 13'd0, src, 1'b0, '0};
   endfunction

   function automatic plan_row_type pinned_beat(input logic [7:0] src,
                                                input logic [DEST_ADDR_BITS-1:0] addr,
                                                input logic [7:0] data,
                                                input logic done, input logic ovf);
      return '{ROW_BEAT, CSR_SPARE, 13'd0, src, 1'b1, '{addr, data, done, ovf}};
   endfunction

   // mostly tiny dims, with the clamp corners mixed in
   function automatic logic [CSR_DATA_BITS-1:0] pick_dim();
      logic [CSR_DATA_BITS-1:0] corners [4];
      corners = '{13'd4095, 13'd4096, 13'd4097, 13'd8191};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 13'($urandom_range(1, 4));
         5:             return 13'd0;
         6:             return corners[$urandom_range(0, 3)];
         7:             return 13'($urandom_range(5, 64));
         8:             return 13'($urandom_range(0, 8191));
         default:       return 13'd1;
      endcase
   endfunction

   // call at a falling edge; returns at a falling edge
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_OUT_CHANNELS:  layout_cfg.out_channels  = val;
         CSR_IN_CHANNELS:   layout_cfg.in_channels   = val;
         CSR_KERNEL_HEIGHT: layout_cfg.kernel_height = val;
         CSR_KERNEL_WIDTH:  layout_cfg.kernel_width  = val;
         CSR_LAYOUT_MODE:   layout_cfg.layout_mode   = val[0];
         CSR_FLIP_SIGN:     layout_cfg.flip_sign     = val[0];
         CSR_ELEMENT_BYTES: layout_cfg.element_bytes = val[2:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // hold the beat until taken; returns at the following falling edge
   task automatic push_beat(input logic [7:0] src, input logic pinned,
                            input placement_type want);
      placement_type predicted;
      csr_we       <= 1'b0;
      req_push     <= 1'b1;
      req_src_byte <= src;
      do begin
         @(posedge clock);
      end while (req_full);
      predicted = place_byte(src);
      if (pinned) begin
         predicted = want;
      end
      pending_placements.insert(pending_placements.size(), predicted);
      beats_sent++;
      @(negedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic settle();
      req_push <= 1'b0;
      while (pending_placements.size() != 0) begin
         @(negedge clock);
      end
      settings++;
   endtask

   // receiver: switch between no stalls, short stalls and long stalls
   initial begin
      int hold_left;
      int pop_style;
      int style_left;
      hold_left  = 0;
      pop_style  = 0;
      style_left = 0;
      forever begin
         @(negedge clock);
         if (style_left == 0) begin
            pop_style  = $urandom_range(0, 2);
            style_left = $urandom_range(50, 400);
         end
         style_left--;
         if (hold_left > 0) begin
            rsp_pop <= 1'b0;
            hold_left--;
         end else begin
            rsp_pop <= 1'b1;
            case (pop_style)
               1: if ($urandom_range(0, 3) == 0) hold_left = $urandom_range(1, 3);
               2: if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(5, 30);
               default: ;
            endcase
         end
      end
   end

   placement_type got_placement;
   placement_type want_placement;

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         got_placement = '{rsp_dest_addr, rsp_dest_byte, rsp_tensor_done, rsp_addr_overflow};
         results_seen++;
         if (got_placement.tensor_done) done_seen++;
         if (got_placement.addr_overflow) ovf_seen++;
         if (pending_placements.size() == 0) begin
            $display("%0t unexpected result beat: addr %h byte %h done %b ovf %b", $time,
                     got_placement.dest_addr, got_placement.dest_byte,
                     got_placement.tensor_done, got_placement.addr_overflow);
            fail_count++;
         end else begin
            want_placement = pending_placements.pop_front();
            if (got_placement.dest_addr !== want_placement.dest_addr) begin
               $display("%0t dest_addr mismatch: expected %h, got %h", $time,
                        want_placement.dest_addr, got_placement.dest_addr);
               fail_count++;
            end
            if (got_placement.dest_byte !== want_placement.dest_byte) begin
               $display("%0t dest_byte mismatch: expected %h, got %h", $time,
                        want_placement.dest_byte, got_placement.dest_byte);
               fail_count++;
            end
            if (got_placement.tensor_done !== want_placement.tensor_done) begin
               $display("%0t tensor_done mismatch: expected %b, got %b", $time,
                        want_placement.tensor_done, got_placement.tensor_done);
               fail_count++;
            end
            if (got_placement.addr_overflow !== want_placement.addr_overflow) begin
               $display("%0t addr_overflow mismatch: expected %b, got %b", $time,
                        want_placement.addr_overflow, got_placement.addr_overflow);
               fail_count++;
            end
         end
      end
   end

   initial begin
      phase_kind_type  phase;
      int              phase_len;
      int              random_beats;
      int              burst_left;
      int              gap;
      longint unsigned tensor_size;

      plan = '{
         // reset settings: every byte is a whole tensor
         pinned_beat(8'h00, 24'd0, 8'h00, 1'b1, 1'b0),
         pinned_beat(8'hFF, 24'd0, 8'hFF, 1'b1, 1'b0),
         reg_write(CSR_FLIP_SIGN, 13'd1),
         pinned_beat(8'h7F, 24'd0, 8'hFF, 1'b1, 1'b0),
         pinned_beat(8'h80, 24'd0, 8'h00, 1'b1, 1'b0),
         reg_write(CSR_FLIP_SIGN, 13'd0),
         // zero dim acts as one, oversize dim clamps to 4096
         reg_write(CSR_OUT_CHANNELS, 13'd0),
         reg_write(CSR_IN_CHANNELS, 13'd8191),
         pinned_beat(8'h11, 24'd0, 8'h11, 1'b0, 1'b0),
         pinned_beat(8'h22, 24'd1, 8'h22, 1'b0, 1'b0),
         // shrink a dim under a counter already past it
         reg_write(CSR_IN_CHANNELS, 13'd2),
         pinned_beat(8'h33, 24'd2, 8'h33, 1'b1, 1'b0),
         // element size 7 clamps to 4, then 0 acts as 1 mid element
         reg_write(CSR_ELEMENT_BYTES, 13'd7),
         pinned_beat(8'h44, 24'd0, 8'h44, 1'b0, 1'b0),
         pinned_beat(8'h55, 24'd1, 8'h55, 1'b0, 1'b0),
         reg_write(CSR_ELEMENT_BYTES, 13'd0),
         pinned_beat(8'h66, 24'd2, 8'h66, 1'b0, 1'b0),
         pinned_beat(8'h77, 24'd1, 8'h77, 1'b1, 1'b0),
         // layout mode 1: out and in swap roles
         reg_write(CSR_OUT_CHANNELS, 13'd2),
         reg_write(CSR_LAYOUT_MODE, 13'd1),
         pinned_beat(8'hA0, 24'd0, 8'hA0, 1'b0, 1'b0),
         pinned_beat(8'hA1, 24'd2, 8'hA1, 1'b0, 1'b0),
         pinned_beat(8'hA2, 24'd1, 8'hA2, 1'b0, 1'b0),
         pinned_beat(8'hA3, 24'd3, 8'hA3, 1'b1, 1'b0),
         // park the row counter at 1, then widen so the address passes 2**24
         reg_write(CSR_LAYOUT_MODE, 13'd0),
         reg_write(CSR_OUT_CHANNELS, 13'd1),
         reg_write(CSR_IN_CHANNELS, 13'd1),
         reg_write(CSR_KERNEL_HEIGHT, 13'd2),
         pinned_beat(8'h5A, 24'd0, 8'h5A, 1'b0, 1'b0),
         reg_write(CSR_KERNEL_WIDTH, 13'd4096),
         reg_write(CSR_IN_CHANNELS, 13'd4096),
         pinned_beat(8'hA5, 24'd0, 8'hA5, 1'b0, 1'b1),
         free_beat(8'hC3),
         // a write to an unused index must change nothing
         reg_write(CSR_SPARE, 13'd8191),
         free_beat(8'h3C)
      };

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < PLAN_LEN; i++) begin
         if (plan[i].kind == ROW_CSR) begin
            if (!csr_we) settle();
            write_csr(plan[i].index, plan[i].wdata);
         end else begin
            push_beat(plan[i].src, plan[i].pinned, plan[i].want);
         end
      end

      random_beats = 0;
      burst_left   = $urandom_range(1, 48);
      phase        = PHASE_SMALL;
      while (random_beats < RANDOM_LEN) begin
         settle();
         case (phase)
            PHASE_SMALL: begin
               write_csr(CSR_OUT_CHANNELS, 13'($urandom_range(0, 3)));
               write_csr(CSR_IN_CHANNELS, 13'($urandom_range(0, 3)));
               write_csr(CSR_KERNEL_HEIGHT, 13'($urandom_range(0, 3)));
               write_csr(CSR_KERNEL_WIDTH, 13'($urandom_range(0, 3)));
               write_csr(CSR_ELEMENT_BYTES, 13'($urandom_range(0, 7)));
               write_csr(CSR_LAYOUT_MODE, 13'($urandom_range(0, 1)));
               write_csr(CSR_FLIP_SIGN, 13'($urandom_range(0, 1)));
               tensor_size = eff_dim(layout_cfg.out_channels) * eff_dim(layout_cfg.in_channels)
                           * eff_dim(layout_cfg.kernel_height)
                           * eff_dim(layout_cfg.kernel_width)
                           * eff_elem(layout_cfg.element_bytes);
               phase_len = int'(tensor_size) * $urandom_range(1, 2) + $urandom_range(0, 3);
               if (phase_len > 64) phase_len = 64;
            end
            PHASE_SUBSET: begin
               for (int r = 0; r <= int'(CSR_SPARE); r++) begin
                  if ($urandom_range(0, 1) == 1) begin
                     case (CSR_INDEX_BITS'(r))
                        CSR_OUT_CHANNELS, CSR_IN_CHANNELS, CSR_KERNEL_HEIGHT,
                        CSR_KERNEL_WIDTH:
                           write_csr(CSR_INDEX_BITS'(r), pick_dim());
                        default:
                           write_csr(CSR_INDEX_BITS'(r), 13'($urandom_range(0, 8191)));
                     endcase
                  end
               end
               phase_len = $urandom_range(1, 40);
            end
            PHASE_STRESS: begin
               // walk the row counter up, one beat per row
               write_csr(CSR_KERNEL_HEIGHT, 13'($urandom_range(64, 8191)));
               write_csr(CSR_KERNEL_WIDTH, 13'($urandom_range(0, 1)));
               write_csr(CSR_ELEMENT_BYTES, 13'($urandom_range(0, 1)));
               write_csr(CSR_LAYOUT_MODE, 13'($urandom_range(0, 1)));
               phase_len = $urandom_range(10, 60);
            end
            default: begin
               write_csr(CSR_KERNEL_WIDTH, 13'($urandom_range(4096, 8191)));
               write_csr(CSR_IN_CHANNELS, 13'($urandom_range(4096, 8191)));
               write_csr(CSR_OUT_CHANNELS, 13'($urandom_range(4096, 8191)));
               write_csr(CSR_FLIP_SIGN, 13'($urandom_range(0, 1)));
               phase_len = $urandom_range(5, 20);
            end
         endcase

         for (int k = 0; k < phase_len; k++) begin
            push_beat(8'($urandom_range(0, 255)), 1'b0, '0);
            random_beats++;
            if (burst_left == 0) begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               if (gap != 0) begin
                  req_push <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
               burst_left = $urandom_range(1, 48);
            end else begin
               burst_left--;
            end
         end

         if (phase == PHASE_STRESS) begin
            phase = PHASE_WIDE;
         end else begin
            case ($urandom_range(0, 3))
               0, 1:    phase = PHASE_SMALL;
               2:       phase = PHASE_SUBSET;
               default: phase = PHASE_STRESS;
            endcase
         end
      end

      settle();
      repeat (20) @(negedge clock);
      $display("Covered %0d beats over %0d register settings, %0d result beats checked.",
               beats_sent, settings, results_seen);
      $display("Saw %0d tensor ends and %0d address overflows.", done_seen, ovf_seen);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("Timed out with %0d results outstanding", pending_placements.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
